### hdl/voxel_face_ao_vertex_emit_top_defines.svh
// assertion macros for the voxel face ao vertex emitter
`ifndef VOXEL_FACE_AO_VERTEX_EMIT_TOP_DEFINES_SVH
`define VOXEL_FACE_AO_VERTEX_EMIT_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VFAO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vfao check failed");

// next-cycle implication, checked outside reset
`define VFAO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vfao check failed");

`endif

### hdl/vfao_pkg.sv
// shared types, codes and tables for the voxel face ao vertex emitter
package vfao_pkg;

   localparam int FACE_COUNT = 6;
   localparam int VERT_COUNT = 6;
   localparam int PICK_COUNT = 8;

   localparam logic [2:0] LAST_VERTEX = 3'd5;

   // face codes
   localparam logic [2:0] FACE_TOP    = 3'd4;
   localparam logic [2:0] FACE_BOTTOM = 3'd5;

   // block type codes
   localparam logic [2:0] BLK_AIR   = 3'd0;
   localparam logic [2:0] BLK_GRASS = 3'd1;
   localparam logic [2:0] BLK_DIRT  = 3'd2;
   localparam logic [2:0] BLK_STONE = 3'd3;
   localparam logic [2:0] BLK_GLASS = 3'd4;

   // atlas tiles
   localparam logic [7:0] TILE_NONE       = 8'd0;
   localparam logic [7:0] TILE_GRASS_SIDE = 8'd1;
   localparam logic [7:0] TILE_GRASS_TOP  = 8'd2;
   localparam logic [7:0] TILE_DIRT       = 8'd3;
   localparam logic [7:0] TILE_STONE      = 8'd4;
   localparam logic [7:0] TILE_GLASS      = 8'd6;

   typedef struct packed {
      logic [2:0]  face;
      logic [2:0]  block_type;
      logic [3:0]  local_x;
      logic [3:0]  local_y;
      logic [3:0]  local_z;
      logic [26:0] neighbor_mask;
   } req_type;

   typedef struct packed {
      logic [2:0]  vertex_index;
      logic [29:0] packed_position;
      logic [25:0] packed_uv_ao;
      logic        last;
   } rsp_type;

   // classified face waiting for emission
   typedef struct packed {
      logic [2:0]       face;
      logic [3:0]       local_x;
      logic [3:0]       local_y;
      logic [3:0]       local_z;
      logic [7:0]       tile;
      logic [3:0][1:0]  ao_levels;
   } face_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // corner offset {x,y,z} per face and vertex
   localparam logic [2:0] CORNER_TAB [FACE_COUNT][VERT_COUNT] = '{
      '{3'b011, 3'b001, 3'b111, 3'b001, 3'b101, 3'b111},
      '{3'b110, 3'b100, 3'b010, 3'b100, 3'b000, 3'b010},
      '{3'b111, 3'b101, 3'b110, 3'b101, 3'b100, 3'b110},
      '{3'b010, 3'b000, 3'b011, 3'b000, 3'b001, 3'b011},
      '{3'b010, 3'b011, 3'b110, 3'b011, 3'b111, 3'b110},
      '{3'b001, 3'b000, 3'b101, 3'b000, 3'b100, 3'b101}
   };

   // mask bit of top, left, bottom, right, tl, tr, bl, br per face
   localparam logic [4:0] PICK_TAB [FACE_COUNT][PICK_COUNT] = '{
      '{5'd17, 5'd5,  5'd11, 5'd23, 5'd8,  5'd26, 5'd2,  5'd20},
      '{5'd15, 5'd21, 5'd9,  5'd3,  5'd24, 5'd6,  5'd18, 5'd0 },
      '{5'd25, 5'd23, 5'd19, 5'd21, 5'd26, 5'd24, 5'd20, 5'd18},
      '{5'd7,  5'd3,  5'd1,  5'd5,  5'd6,  5'd8,  5'd0,  5'd2 },
      '{5'd15, 5'd7,  5'd17, 5'd25, 5'd6,  5'd24, 5'd8,  5'd26},
      '{5'd11, 5'd1,  5'd9,  5'd19, 5'd2,  5'd20, 5'd0,  5'd18}
   };

   // {u,v} per vertex, a set bit means full scale
   localparam logic [1:0] UV_TAB [VERT_COUNT] = '{
      2'b01, 2'b00, 2'b11, 2'b00, 2'b10, 2'b11
   };

   function automatic logic face_ok(input logic [2:0] face);
      return face < 3'(FACE_COUNT);
   endfunction

   function automatic logic [2:0] corner_of(input logic [2:0] face, input logic [2:0] vtx);
      logic [2:0] c;
      c = '0;
      if (face_ok(face) && vtx < 3'(VERT_COUNT)) begin
         c = CORNER_TAB[face][vtx];
      end
      return c;
   endfunction

   function automatic logic [1:0] uv_of(input logic [2:0] vtx);
      logic [1:0] uv;
      uv = '0;
      if (vtx < 3'(VERT_COUNT)) begin
         uv = UV_TAB[vtx];
      end
      return uv;
   endfunction

   function automatic logic [PICK_COUNT-1:0] neighbors_of(input logic [2:0]  face,
                                                          input logic [26:0] mask);
      logic [PICK_COUNT-1:0] nb;
      nb = '0;
      if (face_ok(face)) begin
         for (int k = 0; k < PICK_COUNT; k++) begin
            nb[k] = mask[PICK_TAB[face][k]];
         end
      end
      return nb;
   endfunction

   function automatic logic [1:0] ao_level(input logic side_a, input logic side_b,
                                           input logic corner);
      logic [1:0] lvl;
      if (side_a && side_b) begin
         lvl = 2'd0;
      end else begin
         lvl = 2'd3 - {1'b0, side_a} - {1'b0, side_b} - {1'b0, corner};
      end
      return lvl;
   endfunction

   function automatic logic [7:0] tile_of(input logic [2:0] face, input logic [2:0] btype);
      logic [7:0] t;
      t = TILE_NONE;
      if (face_ok(face)) begin
         case (btype)
            BLK_AIR: begin
               t = TILE_NONE;
            end
            BLK_GRASS: begin
               if (face == FACE_TOP) begin
                  t = TILE_GRASS_TOP;
               end else if (face == FACE_BOTTOM) begin
                  t = TILE_DIRT;
               end else begin
                  t = TILE_GRASS_SIDE;
               end
            end
            BLK_DIRT: begin
               t = TILE_DIRT;
            end
            BLK_STONE: begin
               t = TILE_STONE;
            end
            BLK_GLASS: begin
               t = TILE_GLASS;
            end
            default: begin
               t = TILE_NONE;
            end
         endcase
      end
      return t;
   endfunction

endpackage

### hdl/vfao_front.sv
// front end: picks neighbors, forms corner ao levels and the atlas tile
module vfao_front (
   input  vfao_pkg::req_type       item,
   output vfao_pkg::face_desc_type desc
);
   import vfao_pkg::*;

   logic [PICK_COUNT-1:0] nb;

   // nb: top, left, bottom, right, tl, tr, bl, br
   assign nb = neighbors_of(item.face, item.neighbor_mask);

   always_comb begin
      desc.face         = item.face;
      desc.local_x      = item.local_x;
      desc.local_y      = item.local_y;
      desc.local_z      = item.local_z;
      desc.tile         = tile_of(item.face, item.block_type);
      desc.ao_levels[0] = ao_level(nb[0], nb[1], nb[4]);
      desc.ao_levels[1] = ao_level(nb[0], nb[3], nb[5]);
      desc.ao_levels[2] = ao_level(nb[2], nb[1], nb[6]);
      desc.ao_levels[3] = ao_level(nb[2], nb[3], nb[7]);
   end

endmodule

### hdl/vfao_queue.sv
// short fifo of classified faces between front and back
module vfao_queue #(
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  vfao_pkg::face_desc_type push_data,
   input  logic                    pop,
   output vfao_pkg::face_desc_type pop_data,
   output vfao_pkg::q_stat_type    status
);
   import vfao_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   face_desc_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);

endmodule

### hdl/vfao_back.sv
// back end: walks the six vertices of a face and drives the result beats
module vfao_back (
   input  logic                    clock,
   input  logic                    reset,
   input  vfao_pkg::q_stat_type    status,
   input  vfao_pkg::face_desc_type pop_data,
   output logic                    pop,
   output logic                    rsp_valid,
   output vfao_pkg::rsp_type       rsp_item
);
   import vfao_pkg::*;

   logic          active_ff, active_in;
   logic [2:0]    vtx_ff, vtx_in;
   face_desc_type cur_ff, cur_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [2:0] corner;
   logic [1:0] uv;
   logic [4:0] sum_x, sum_y, sum_z;

   // next face loads when idle or on the closing vertex
   assign pop = (!active_ff || vtx_ff == LAST_VERTEX) && !status.empty;

   always_comb begin
      active_in = active_ff;
      vtx_in    = vtx_ff;
      cur_in    = cur_ff;
      if (pop) begin
         cur_in    = pop_data;
         vtx_in    = '0;
         active_in = 1'b1;
      end else if (active_ff && vtx_ff == LAST_VERTEX) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         vtx_in = vtx_ff + 1'b1;
      end
   end

   always_comb begin
      corner = corner_of(cur_ff.face, vtx_ff);
      uv     = uv_of(vtx_ff);
      sum_x  = {4'b0, corner[2]} + {1'b0, cur_ff.local_x};
      sum_y  = {4'b0, corner[1]} + {1'b0, cur_ff.local_y};
      sum_z  = {4'b0, corner[0]} + {1'b0, cur_ff.local_z};
      rsp_valid_in           = active_ff;
      rsp_in.vertex_index    = vtx_ff;
      rsp_in.packed_position = {1'b0, sum_z, 4'b0, 1'b0, sum_y, 4'b0, 1'b0, sum_x, 4'b0};
      rsp_in.packed_uv_ao    = {cur_ff.ao_levels[3], 2'b00, cur_ff.ao_levels[2],
                                cur_ff.ao_levels[1], cur_ff.ao_levels[0], cur_ff.tile,
                                {4{uv[0]}}, {4{uv[1]}}};
      rsp_in.last            = (vtx_ff == LAST_VERTEX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         vtx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         vtx_ff       <= vtx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### hdl/voxel_face_ao_vertex_emit_top.sv
// voxel face mesher top level: emits six ao-shaded vertices per visible face
//
// input channel: a face beat (req_item) is taken at a rising edge with start high
//   and busy low; busy is high only while the face queue is full
// result channel: each vertex beat sits on rsp_item for one cycle with rsp_valid
//   high; the receiver cannot hold beats off, so none is ever stalled
// the first vertex of a face passes through a queue entry, the back end's face
//   register and the result register; vertices 0..5 follow on consecutive cycles
// the single vertex port of the back end takes the next face only on the closing
//   vertex of its current face; queued faces follow with no gap between vertex runs
// the queue holds QUEUE_DEPTH classified faces, so a few faces can be taken
//   ahead of the back end before busy rises
// reset: synchronous, active high; empties the queue and stops any vertex run,
//   no beat is shown in the cycle after reset
// unknown face codes still give six vertices, at zero corner offsets, ao
//   levels of three and tile zero; unknown block types give tile zero
`include "voxel_face_ao_vertex_emit_top_defines.svh"

module voxel_face_ao_vertex_emit_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vfao_pkg::req_type req_item,
   output logic              rsp_valid,
   output vfao_pkg::rsp_type rsp_item
);
   import vfao_pkg::*;

   face_desc_type front_desc;
   face_desc_type q_head;
   q_stat_type    q_status;
   logic          q_push;
   logic          q_pop;

   // classify the incoming face
   vfao_front u_front (
      .item (req_item),
      .desc (front_desc)
   );

   // accepted faces go straight into the queue
   assign busy   = q_status.full;
   assign q_push = start && !busy;

   vfao_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_desc),
      .pop       (q_pop),
      .pop_data  (q_head),
      .status    (q_status)
   );

   // vertex sequencer and registered result beat
   vfao_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (q_status),
      .pop_data  (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // a face is only loaded from a non-empty queue
   `VFAO_ASSERT_NOW(a_pop_not_empty, clock, reset, q_pop, !q_status.empty)

   // last marks exactly the closing vertex
   `VFAO_ASSERT_NOW(a_last_on_final, clock, reset, rsp_valid,
                    rsp_item.last == (rsp_item.vertex_index == LAST_VERTEX))

   // a vertex run is never broken before its closing vertex
   `VFAO_ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && !rsp_item.last,
                     rsp_valid && rsp_item.vertex_index == $past(rsp_item.vertex_index) + 3'd1)

   // a run always starts at vertex zero
   `VFAO_ASSERT_NEXT(a_run_starts_zero, clock, reset, !rsp_valid || rsp_item.last,
                     !rsp_valid || rsp_item.vertex_index == 3'd0)

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the voxel face ao vertex emitter
module tb;
   import vfao_pkg::*;

   // cycles with neither a face accepted nor a vertex shown before giving up
   localparam int WATCHDOG_LIMIT = 1000;
   // quiet cycles waited after the last expected vertex has been seen
   localparam int SETTLE_CYCLES  = 20;
   localparam int REPORT_LIMIT   = 10;
   localparam int KNOWN_BLOCKS   = 5;

   // order of the eight occluders picked per face
   localparam int NB_TOP    = 0;
   localparam int NB_LEFT   = 1;
   localparam int NB_BOTTOM = 2;
   localparam int NB_RIGHT  = 3;
   localparam int NB_TL     = 4;
   localparam int NB_TR     = 5;
   localparam int NB_BL     = 6;
   localparam int NB_BR     = 7;

   // {x,y,z} corner offset of each vertex, two triangles per face
   localparam logic [2:0] corner_offsets [FACE_COUNT][VERT_COUNT] = '{
      '{3'b011, 3'b001, 3'b111, 3'b001, 3'b101, 3'b111},
      '{3'b110, 3'b100, 3'b010, 3'b100, 3'b000, 3'b010},
      '{3'b111, 3'b101, 3'b110, 3'b101, 3'b100, 3'b110},
      '{3'b010, 3'b000, 3'b011, 3'b000, 3'b001, 3'b011},
      '{3'b010, 3'b011, 3'b110, 3'b011, 3'b111, 3'b110},
      '{3'b001, 3'b000, 3'b101, 3'b000, 3'b100, 3'b101}
   };

   // neighbor mask bit (x*9 + y*3 + z) of each occluder, per face
   localparam logic [4:0] occluder_bits [FACE_COUNT][PICK_COUNT] = '{
      '{5'd17, 5'd5,  5'd11, 5'd23, 5'd8,  5'd26, 5'd2,  5'd20},
      '{5'd15, 5'd21, 5'd9,  5'd3,  5'd24, 5'd6,  5'd18, 5'd0 },
      '{5'd25, 5'd23, 5'd19, 5'd21, 5'd26, 5'd24, 5'd20, 5'd18},
      '{5'd7,  5'd3,  5'd1,  5'd5,  5'd6,  5'd8,  5'd0,  5'd2 },
      '{5'd15, 5'd7,  5'd17, 5'd25, 5'd6,  5'd24, 5'd8,  5'd26},
      '{5'd11, 5'd1,  5'd9,  5'd19, 5'd2,  5'd20, 5'd0,  5'd18}
   };

   // {u,v} per vertex, set bit means 15
   localparam logic [1:0] uv_full [VERT_COUNT] = '{
      2'b01, 2'b00, 2'b11, 2'b00, 2'b10, 2'b11
   };

   // atlas tile by block type and face
   localparam logic [7:0] atlas_tiles [KNOWN_BLOCKS][FACE_COUNT] = '{
      '{TILE_NONE, TILE_NONE, TILE_NONE, TILE_NONE, TILE_NONE, TILE_NONE},
      '{TILE_GRASS_SIDE, TILE_GRASS_SIDE, TILE_GRASS_SIDE, TILE_GRASS_SIDE,
        TILE_GRASS_TOP, TILE_DIRT},
      '{TILE_DIRT, TILE_DIRT, TILE_DIRT, TILE_DIRT, TILE_DIRT, TILE_DIRT},
      '{TILE_STONE, TILE_STONE, TILE_STONE, TILE_STONE, TILE_STONE, TILE_STONE},
      '{TILE_GLASS, TILE_GLASS, TILE_GLASS, TILE_GLASS, TILE_GLASS, TILE_GLASS}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   // vertices predicted for accepted faces, oldest first
   rsp_type vertex_q [$];
   int      fail_count  = 0;
   int      idle_pct    = 0;
   int      quiet_cycles = 0;

   voxel_face_ao_vertex_emit_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // corner ao: both sides blocked darkens fully, else one step per occluder
   function automatic logic [1:0] occlusion(input logic side_a, input logic side_b,
                                            input logic corner);
      if (side_a && side_b) begin
         return 2'd0;
      end
      return 2'(3 - int'(side_a) - int'(side_b) - int'(corner));
   endfunction

   // predicts the six vertex beats of one face and queues them
   function automatic void queue_face_vertices(input req_type f);
      logic                  known;
      logic [PICK_COUNT-1:0] nb;
      logic [25:0]           shade;
      logic [7:0]            tile;
      logic [2:0]            c;
      logic [9:0]            px;
      logic [9:0]            py;
      logic [9:0]            pz;
      rsp_type               v;
      int                    k;
      known = f.face < 3'(FACE_COUNT);
      nb    = '0;
      tile  = TILE_NONE;
      // unknown faces pick no occluders and map to tile zero
      if (known) begin
         for (k = 0; k < PICK_COUNT; k++) begin
            nb[k] = f.neighbor_mask[occluder_bits[f.face][k]];
         end
         if (f.block_type < 3'(KNOWN_BLOCKS)) begin
            tile = atlas_tiles[f.block_type][f.face];
         end
      end
      shade        = '0;
      shade[17:16] = occlusion(nb[NB_TOP], nb[NB_LEFT], nb[NB_TL]);
      shade[19:18] = occlusion(nb[NB_TOP], nb[NB_RIGHT], nb[NB_TR]);
      shade[21:20] = occlusion(nb[NB_BOTTOM], nb[NB_LEFT], nb[NB_BL]);
      // the fourth level sits at bit 24, bits 22-23 stay clear
      shade[25:24] = occlusion(nb[NB_BOTTOM], nb[NB_RIGHT], nb[NB_BR]);
      shade[15:8]  = tile;
      for (k = 0; k < VERT_COUNT; k++) begin
         c  = known ? corner_offsets[f.face][k] : 3'b000;
         px = (10'(c[2]) + 10'(f.local_x)) << 4;
         py = (10'(c[1]) + 10'(f.local_y)) << 4;
         pz = (10'(c[0]) + 10'(f.local_z)) << 4;
         v.vertex_index      = 3'(k);
         v.packed_position   = {pz, py, px};
         v.packed_uv_ao      = shade;
         v.packed_uv_ao[3:0] = uv_full[k][1] ? 4'hf : 4'h0;
         v.packed_uv_ao[7:4] = uv_full[k][0] ? 4'hf : 4'h0;
         v.last              = (k == VERT_COUNT - 1);
         vertex_q = {vertex_q, v};
      end
   endfunction

   function automatic logic [3:0] random_coord();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom_range(0, 1) ? 4'hf : 4'h0;
      end
      return 4'($urandom_range(0, 15));
   endfunction

   // any face and block code, including the unknown ones
   function automatic req_type random_face();
      req_type f;
      int      density;
      f.face       = 3'($urandom_range(0, 7));
      f.block_type = 3'($urandom_range(0, 7));
      f.local_x    = random_coord();
      f.local_y    = random_coord();
      f.local_z    = random_coord();
      density      = $urandom_range(0, 3);
      // mix sparse and dense neighborhoods so every ao level shows up
      if (density == 0) begin
         f.neighbor_mask = 27'($urandom & $urandom & $urandom);
      end else if (density == 1) begin
         f.neighbor_mask = 27'($urandom | $urandom);
      end else begin
         f.neighbor_mask = 27'($urandom);
      end
      return f;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch: %s expected %h got %h", field, want, got);
         end
      end
   endtask

   // scoreboard, accept monitor and watchdog, all on the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         // a vertex beat is only shown for one cycle, so take it now
         if (rsp_valid) begin
            if (vertex_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("mismatch: unexpected vertex beat %h", rsp_item);
               end
            end else begin
               want = vertex_q.pop_front();
               check_field("vertex_index", 32'(want.vertex_index),
                           32'(rsp_item.vertex_index));
               check_field("packed_position", 32'(want.packed_position),
                           32'(rsp_item.packed_position));
               check_field("packed_uv_ao", 32'(want.packed_uv_ao),
                           32'(rsp_item.packed_uv_ao));
               check_field("last", 32'(want.last), 32'(rsp_item.last));
            end
         end
         // face beat taken at this edge: its vertices come out after the queue and back end
         if (start && !busy) begin
            queue_face_vertices(req_item);
         end
         quiet_cycles = ((start && !busy) || rsp_valid) ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // offers one face until taken, then maybe idles a random stretch
   task automatic send_face(input req_type f);
      req_item <= f;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      // start stays high when the next face follows with no gap
      if ($urandom_range(0, 99) < idle_pct) begin
         start    <= 1'b0;
         req_item <= random_face();
         do begin
            @(posedge clock);
         end while ($urandom_range(0, 99) < idle_pct);
      end
   endtask

   // sender holds off until every predicted vertex has been seen
   task automatic wait_for_drain();
      start <= 1'b0;
      while (vertex_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all face and block codes, coordinate extremes, each ao level per face
   task automatic test_corner_cases();
      req_type f;
      int      i;
      for (i = 0; i < 8; i++) begin
         f.face          = 3'(i);
         f.block_type    = 3'(i);
         f.local_x       = i[0] ? 4'hf : 4'h0;
         f.local_y       = i[2] ? 4'h0 : 4'hf;
         f.local_z       = i[0] ? 4'hf : 4'h0;
         f.neighbor_mask = i[1] ? '1 : '0;
         send_face(f);
      end
      for (i = 0; i < FACE_COUNT; i++) begin
         // top and left blocked: top-left fully dark, the others one step
         f.face          = 3'(i);
         f.block_type    = BLK_GRASS;
         f.local_x       = random_coord();
         f.local_y       = random_coord();
         f.local_z       = random_coord();
         f.neighbor_mask = '0;
         f.neighbor_mask[occluder_bits[i][NB_TOP]]  = 1'b1;
         f.neighbor_mask[occluder_bits[i][NB_LEFT]] = 1'b1;
         f.neighbor_mask[occluder_bits[i][NB_BR]]   = 1'b1;
         send_face(f);
         // right, bottom and two corners: levels 3, 1, 1, 0
         f.neighbor_mask = '0;
         f.neighbor_mask[occluder_bits[i][NB_RIGHT]]  = 1'b1;
         f.neighbor_mask[occluder_bits[i][NB_BOTTOM]] = 1'b1;
         f.neighbor_mask[occluder_bits[i][NB_TR]]     = 1'b1;
         f.neighbor_mask[occluder_bits[i][NB_BL]]     = 1'b1;
         send_face(f);
      end
   endtask

   task automatic test_random_faces(input int count, input int pct);
      int i;
      idle_pct = pct;
      for (i = 0; i < count; i++) begin
         send_face(random_face());
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 29;
      test_corner_cases();
      wait_for_drain();
      // sender gaps first sparse, then frequent, then none so busy backs up
      test_random_faces(100, 29);
      wait_for_drain();
      test_random_faces(100, 46);
      wait_for_drain();
      test_random_faces(90, 0);
      wait_for_drain();

      if (fail_count == 0 && vertex_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/vfao_pkg.sv
hdl/vfao_front.sv
hdl/vfao_queue.sv
hdl/vfao_back.sv
hdl/voxel_face_ao_vertex_emit_top.sv
tb/tb.sv
